/* hdl/vout_pkg.sv */
package vout_pkg;

	// Defaults for the top-level parameters.
	localparam int PALETTE_ENTRIES_DEF  = 256;
	localparam int VRAM_OFFSET_BITS_DEF = 22;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Request kinds.
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;

	// Byte ports.
	localparam logic [1:0] PORT_TDATA  = 2'd0;
	localparam logic [1:0] PORT_TADDR  = 2'd1;
	localparam logic [1:0] PORT_CDATA  = 2'd2;
	localparam logic [1:0] PORT_CINDEX = 2'd3;

	// Control register indices. Indices below GEO_REGS are timing, base and pitch bytes.
	localparam int         GEO_REGS        = 17;
	localparam logic [7:0] IDX_CONTROL_ONE = 8'd23;

	// Control register 1 bits.
	localparam logic [7:0] CTL1_WMASK   = 8'hFD;
	localparam int         CTL1_ZOOM    = 2;
	localparam int         CTL1_IRQ_EN  = 6;
	localparam int         CTL1_STATUS  = 7;

	// Pixel formats and depth codes.
	localparam logic [1:0] FMT_8     = 2'd1;
	localparam logic [1:0] FMT_16    = 2'd2;
	localparam logic [1:0] DEPTH_8   = 2'd0;
	localparam logic [1:0] DEPTH_16  = 2'd1;
	localparam logic [1:0] DEPTH_32  = 2'd2;

	// Odd field end above this line count means 50 Hz.
	localparam logic [15:0] RATE50_LINES = 16'd256;

endpackage

/* hdl/vout_ram.sv */
module vout_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/video_out_clut_and_timing_regs_top.sv */
// Channel   Direction  tdata (low bit up)                                  tuser (low bit up)
// s_axis    in         wdata[7:0], line_state[8], zero to 16 bits          req_type[1:0], port[3:2]
// m_axis    out        rdata, display_on, vis_width, vis_height,           none
//                      depth_code, rate_50hz, fb_offset, line_bytes,
//                      irq_drive, irq_level, zero to whole bytes
//
// The accept cycle issues the palette read; the execute state then takes the registered
// RAM data and commits all state and the result.
// The palette RAM's registered read is why the commit waits for the execute state.
// Reset clears the sequencer, output valid, component, address, index, control and geometry
// registers (display off); the palette is not cleared and holds whatever was last written.
// The execute state stalls while a previous result still waits in the output register.

module video_out_clut_and_timing_regs_top #(
	parameter int PALETTE_ENTRIES  = vout_pkg::PALETTE_ENTRIES_DEF,
	parameter int VRAM_OFFSET_BITS = vout_pkg::VRAM_OFFSET_BITS_DEF,
	localparam int OUT_BITS = 68 + VRAM_OFFSET_BITS,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // wdata[7:0], line_state[8]
	input  logic [3:0]       s_axis_tuser,  // req_type[1:0], port[3:2]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // rdata, display_on, vis_width,
	                                        // vis_height, depth_code, rate_50hz,
	                                        // fb_offset, line_bytes, irq_drive, irq_level
);

	localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
	localparam int DRV_BIT = 66 + VRAM_OFFSET_BITS;
	localparam int LVL_BIT = 67 + VRAM_OFFSET_BITS;

	vout_pkg::state_t state_q, state_n;

	logic       s_fire;
	logic       go;
	logic [1:0] req_q;
	logic [1:0] port_q;
	logic [7:0] wd_q;
	logic       line_q;

	logic [1:0] ptr_q, ptr_n;
	logic [7:0] comp_q [3];
	logic [7:0] comp_n [3];
	logic [7:0] loaded [3];
	logic [7:0] taddr_q, taddr_n;
	logic [7:0] cidx_q, cidx_n;
	logic [7:0] ctl_q [vout_pkg::GEO_REGS];
	logic       ctl_we;
	logic [7:0] ctl1_q, ctl1_n;
	logic       dirty_q, dirty_n;
	logic       irq_en_q, irq_en_n;
	logic [1:0] fmt_q, fmt_n;

	logic                        geo_on_q, geo_on_n;
	logic signed [16:0]          geo_w_q, geo_w_n;
	logic signed [17:0]          geo_h_q, geo_h_n;
	logic [1:0]                  geo_depth_q, geo_depth_n;
	logic                        geo_rate_q, geo_rate_n;
	logic [VRAM_OFFSET_BITS-1:0] geo_off_q, geo_off_n;
	logic [18:0]                 geo_bytes_q, geo_bytes_n;

	logic [7:0] rd;
	logic       drive;
	logic       lvl;
	logic       recompute;

	logic              m_valid_q;
	logic [OUT_BITS-1:0] m_data_q;

	// Palette index: table address taken modulo the table size.
	logic [PAL_AW-1:0] mod_lut [256];
	logic [PAL_AW-1:0] pal_idx;
	logic              pal_we;
	logic [23:0]       pal_wdata;
	logic [23:0]       pal_rdata;

	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign mod_lut[i] = PAL_AW'(i % PALETTE_ENTRIES);
	end

	assign pal_idx   = mod_lut[taddr_q];
	assign pal_wdata = {comp_n[0], comp_n[1], wd_q};

	vout_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_idx),
		.wdata (pal_wdata),
		.re    (s_fire),
		.raddr (pal_idx),
		.rdata (pal_rdata)
	);

	// Geometry from the current timing bytes and the new control register 1.
	logic [15:0]        hs, he, v0, v1, v2, v3, pitch;
	logic [23:0]        base;
	logic [26:0]        base_x8;
	logic signed [16:0] w_full, w_calc;
	logic signed [17:0] s_sum, h_even, h_calc;

	always_comb begin
		hs      = {ctl_q[9], ctl_q[8]};
		he      = {ctl_q[11], ctl_q[10]};
		v0      = {ctl_q[1], ctl_q[0]};
		v1      = {ctl_q[3], ctl_q[2]};
		v2      = {ctl_q[5], ctl_q[4]};
		v3      = {ctl_q[7], ctl_q[6]};
		base    = {ctl_q[14], ctl_q[13], ctl_q[12]};
		pitch   = {ctl_q[16], ctl_q[15]};
		base_x8 = {base, 3'b000};
		w_full  = $signed({1'b0, he}) - $signed({1'b0, hs});
		s_sum   = $signed({2'b00, v1}) - $signed({2'b00, v0})
		        + $signed({2'b00, v3}) - $signed({2'b00, v2}) + 18'sd1;
		h_even  = $signed({s_sum[17:1], 1'b0});
		if (ctl1_n[vout_pkg::CTL1_ZOOM]) begin
			w_calc = w_full >>> 1;
			h_calc = h_even >>> 1;
		end else begin
			w_calc = w_full;
			h_calc = h_even;
		end
	end

	always_comb begin
		loaded[0] = (ptr_q == 2'd0) ? pal_rdata[23:16] : comp_q[0];
		loaded[1] = (ptr_q == 2'd0) ? pal_rdata[15:8]  : comp_q[1];
		loaded[2] = (ptr_q == 2'd0) ? pal_rdata[7:0]   : comp_q[2];
	end

	// Execute: read-modify-write of the component buffer and register file.
	always_comb begin
		comp_n    = comp_q;
		ptr_n     = ptr_q;
		taddr_n   = taddr_q;
		cidx_n    = cidx_q;
		ctl1_n    = ctl1_q;
		dirty_n   = dirty_q;
		irq_en_n  = irq_en_q;
		ctl_we    = 1'b0;
		pal_we    = 1'b0;
		recompute = 1'b0;
		rd        = 8'd0;
		drive     = 1'b0;
		lvl       = 1'b0;

		case (req_q)
			vout_pkg::REQ_READ: begin
				case (port_q)
					vout_pkg::PORT_TDATA: begin
						comp_n = loaded;
						rd     = loaded[ptr_q];
					end
					vout_pkg::PORT_TADDR: rd = taddr_q;
					vout_pkg::PORT_CDATA:
						rd = (cidx_q == vout_pkg::IDX_CONTROL_ONE) ? ctl1_q : 8'd0;
					default: rd = cidx_q;
				endcase
			end
			vout_pkg::REQ_WRITE: begin
				case (port_q)
					vout_pkg::PORT_TDATA: begin
						comp_n        = loaded;
						comp_n[ptr_q] = wd_q;
						// The entry is written only in the commit cycle of its blue beat.
						pal_we        = go && (ptr_q == 2'd2);
					end
					vout_pkg::PORT_TADDR: taddr_n = wd_q;
					vout_pkg::PORT_CDATA: begin
						if (cidx_q < 8'(vout_pkg::GEO_REGS)) begin
							ctl_we  = 1'b1;
							dirty_n = 1'b1;
						end else if (cidx_q == vout_pkg::IDX_CONTROL_ONE) begin
							ctl1_n = wd_q & vout_pkg::CTL1_WMASK;
							if (wd_q[vout_pkg::CTL1_IRQ_EN]) begin
								irq_en_n = 1'b1;
							end
							if (dirty_q || wd_q[5:4] != fmt_q) begin
								recompute = 1'b1;
								dirty_n   = 1'b0;
							end
						end
						// Cursor, count and control 2 bytes have no visible effect.
					end
					default: cidx_n = wd_q;
				endcase
			end
			vout_pkg::REQ_EVENT: begin
				ctl1_n[vout_pkg::CTL1_STATUS] = line_q;
				if (irq_en_q && geo_on_q) begin
					drive = 1'b1;
					lvl   = line_q;
				end
			end
			default: ;
		endcase

		// Component pointer steps on every table data access; address moves after blue; a table address write resets it.
		if (port_q == vout_pkg::PORT_TDATA
				&& (req_q == vout_pkg::REQ_READ || req_q == vout_pkg::REQ_WRITE)) begin
			if (ptr_q == 2'd2) begin
				ptr_n   = 2'd0;
				taddr_n = taddr_q + 8'd1;
			end else begin
				ptr_n = ptr_q + 2'd1;
			end
		end else if (port_q == vout_pkg::PORT_TADDR && req_q == vout_pkg::REQ_WRITE) begin
			ptr_n = 2'd0;
		end
	end

	always_comb begin
		geo_on_n    = geo_on_q;
		geo_w_n     = geo_w_q;
		geo_h_n     = geo_h_q;
		geo_depth_n = geo_depth_q;
		geo_rate_n  = geo_rate_q;
		geo_off_n   = geo_off_q;
		geo_bytes_n = geo_bytes_q;
		fmt_n       = fmt_q;
		if (recompute) begin
			geo_w_n     = w_calc;
			geo_h_n     = h_calc;
			geo_on_n    = (w_calc > 17'sd0) && (h_calc > 18'sd0);
			fmt_n       = ctl1_n[5:4];
			geo_rate_n  = (v1 > vout_pkg::RATE50_LINES);
			geo_off_n   = base_x8[VRAM_OFFSET_BITS-1:0];
			geo_bytes_n = {pitch, 3'b000};
			case (ctl1_n[5:4])
				vout_pkg::FMT_8:  geo_depth_n = vout_pkg::DEPTH_8;
				vout_pkg::FMT_16: geo_depth_n = vout_pkg::DEPTH_16;
				default:          geo_depth_n = vout_pkg::DEPTH_32;
			endcase
		end
	end

	// Sequencer.
	always_comb begin
		state_n       = state_q;
		s_axis_tready = (state_q == vout_pkg::ST_IDLE);
		go            = 1'b0;
		case (state_q)
			vout_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_n = vout_pkg::ST_EXEC;
				end
			end
			vout_pkg::ST_EXEC: begin
				go = !m_valid_q || m_axis_tready;
				if (go) begin
					state_n = vout_pkg::ST_IDLE;
				end
			end
			default: state_n = vout_pkg::ST_IDLE;
		endcase
	end

	assign s_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vout_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_q  <= s_axis_tuser[1:0];
			port_q <= s_axis_tuser[3:2];
			wd_q   <= s_axis_tdata[7:0];
			line_q <= s_axis_tdata[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= 2'd0;
			comp_q      <= '{default: 8'd0};
			taddr_q     <= 8'd0;
			cidx_q      <= 8'd0;
			ctl_q       <= '{default: 8'd0};
			ctl1_q      <= 8'd0;
			dirty_q     <= 1'b0;
			irq_en_q    <= 1'b0;
			fmt_q       <= 2'd0;
			geo_on_q    <= 1'b0;
			geo_w_q     <= '0;
			geo_h_q     <= '0;
			geo_depth_q <= vout_pkg::DEPTH_8;
			geo_rate_q  <= 1'b0;
			geo_off_q   <= '0;
			geo_bytes_q <= '0;
		end else if (go) begin
			ptr_q       <= ptr_n;
			comp_q      <= comp_n;
			taddr_q     <= taddr_n;
			cidx_q      <= cidx_n;
			ctl1_q      <= ctl1_n;
			dirty_q     <= dirty_n;
			irq_en_q    <= irq_en_n;
			fmt_q       <= fmt_n;
			geo_on_q    <= geo_on_n;
			geo_w_q     <= geo_w_n;
			geo_h_q     <= geo_h_n;
			geo_depth_q <= geo_depth_n;
			geo_rate_q  <= geo_rate_n;
			geo_off_q   <= geo_off_n;
			geo_bytes_q <= geo_bytes_n;
			for (int i = 0; i < vout_pkg::GEO_REGS; i++) begin
				if (ctl_we && cidx_q == 8'(i)) begin
					ctl_q[i] <= wd_q;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_data_q <= {lvl, drive, geo_bytes_n, geo_off_n, geo_rate_n, geo_depth_n,
				geo_h_n, geo_w_n, geo_on_n, rd};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'(m_data_q);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_axis_tready)
		else $error("beat accepted while another beat is in execution");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q != 2'd3)
		else $error("component pointer out of range");

	a_display_on: assert property (@(posedge clk) disable iff (!arst_n)
		geo_on_q |-> (geo_w_q > 17'sd0 && geo_h_q > 18'sd0))
		else $error("display on with empty active area");

	a_irq_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[LVL_BIT]) |-> m_axis_tdata[DRV_BIT])
		else $error("interrupt level without interrupt drive");

endmodule
